>>> sv/irl_pkg.sv
// ----------------------------------------------------------------------------
// irl_pkg
// Types, codes and constants shared by the image loader front end, command
// queue, back end and top level.
// ----------------------------------------------------------------------------
package irl_pkg;

  // result kinds
  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_FILL  = 2'd1,
    KIND_DONE  = 2'd2
  } kind_t;

  // done status codes
  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_TOO_SHORT  = 3'd1,
    ST_BAD_MAGIC  = 3'd2,
    ST_BAD_MAPPER = 3'd3,
    ST_TOO_LARGE  = 3'd4,
    ST_TRUNCATED  = 3'd5
  } status_t;

  // parser phase
  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_LOAD   = 2'd1,
    PH_DONE   = 2'd2
  } phase_t;

  // configuration register indexes
  localparam int unsigned CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_ROM_LENGTH = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LOAD_BASE  = 2'd1;

  // reset values and layout constants
  localparam logic [31:0] LOAD_BASE_RST = 32'h2000_0400;
  localparam logic [23:0] HDR_LEN       = 24'd16;
  localparam logic [3:0]  HDR_LAST_IDX  = 4'd15;
  localparam logic [15:0] PRG_UNIT      = 16'h4000;
  localparam logic [15:0] CHR_OFFSET    = 16'h8000;
  localparam logic [15:0] VRAM_OFFSET   = 16'hA000;
  localparam logic [15:0] WRAM_OFFSET   = 16'hA800;
  localparam logic [13:0] CHR_RAM_LEN   = 14'h2000;
  localparam logic [13:0] SMALL_RAM_LEN = 14'h0800;
  localparam logic [7:0]  FLAG_HI_MASK  = 8'hF0;
  localparam logic [7:0]  MAX_PRG_BLKS  = 8'd2;
  localparam logic [7:0]  MAX_CHR_BLKS  = 8'd1;

  // result steps a command can expand into, in emission order
  localparam int unsigned NUM_STEPS      = 6;
  localparam int unsigned STEP_WRITE     = 0;
  localparam int unsigned STEP_MIRROR    = 1;
  localparam int unsigned STEP_CHR_FILL  = 2;
  localparam int unsigned STEP_VRAM_FILL = 3;
  localparam int unsigned STEP_WRAM_FILL = 4;
  localparam int unsigned STEP_DONE      = 5;

  // input item
  typedef struct packed {
    logic [7:0] rom_byte;
    logic       first;
  } in_item_t;

  // result item
  typedef struct packed {
    kind_t       kind;
    logic [31:0] address;
    logic [7:0]  data;
    logic [13:0] fill_length;
    status_t     status;
    logic [15:0] flags;
    logic        last;
  } result_t;

  // command from front end to back end
  typedef struct packed {
    logic        has_write;  // byte write at offset
    logic        mirror;     // second copy at offset + one program block
    logic        finish;     // fills and done after any write
    logic        chr_zero;   // character ram fill needed
    status_t     status;     // error status when finish is low and no write
    logic [7:0]  data;
    logic [15:0] offset;
    logic [15:0] flags;
  } cmd_t;

  // expected header magic
  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] val;
    case (idx)
      2'd0:    val = 8'h4E;
      2'd1:    val = 8'h45;
      2'd2:    val = 8'h53;
      default: val = 8'h1A;
    endcase
    return val;
  endfunction

endpackage

>>> sv/irl_front.sv
// ----------------------------------------------------------------------------
// irl_front
// Header parser and byte classifier. Tracks the image position and turns
// each accepted byte into at most one command for the back end.
// ----------------------------------------------------------------------------
module irl_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  irl_pkg::in_item_t in_item,
  input  logic [23:0]      rom_length,
  output logic             cmd_valid,
  output irl_pkg::cmd_t    cmd
);
  import irl_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  hdr_idx_r, hdr_idx_nxt;
  logic        magic_r, magic_nxt;
  logic [7:0]  prg_r, prg_nxt;
  logic [7:0]  chr_r, chr_nxt;
  logic [7:0]  flag6_r, flag6_nxt;
  logic [7:0]  mapper_r, mapper_nxt;
  logic [15:0] off_r, off_nxt;
  logic [15:0] prg_len_r, prg_len_nxt;
  logic [15:0] total_r, total_nxt;
  logic [15:0] flags_r, flags_nxt;

  // state as seen by this byte, after a possible restart
  phase_t      e_phase;
  logic [3:0]  e_idx;
  logic        e_magic;
  logic [7:0]  e_prg;
  logic [7:0]  e_chr;
  logic [7:0]  e_flag6;
  logic [7:0]  e_mapper;

  logic [7:0]  b;
  logic [16:0] need_len;
  logic [15:0] ok_flags;
  logic        magic_bad;

  assign b = in_item.rom_byte;

  // restart view
  always_comb begin
    if (in_item.first) begin
      e_phase  = PH_HEADER;
      e_idx    = '0;
      e_magic  = 1'b1;
      e_prg    = '0;
      e_chr    = '0;
      e_flag6  = '0;
      e_mapper = '0;
    end else begin
      e_phase  = phase_r;
      e_idx    = hdr_idx_r;
      e_magic  = magic_r;
      e_prg    = prg_r;
      e_chr    = chr_r;
      e_flag6  = flag6_r;
      e_mapper = mapper_r;
    end
  end

  // image length needed for the header and the declared sections
  assign need_len = 17'(HDR_LEN) + {1'b0, e_prg[1:0], 14'd0} + {3'b000, e_chr[0], 13'd0};
  assign ok_flags = {(e_chr == 8'd0), e_flag6[0], 3'b000, 3'((e_prg == MAX_PRG_BLKS)),
                     e_mapper};
  assign magic_bad = (e_idx < 4'd4) && (b != magic_byte(e_idx[1:0]));

  // classify the byte and compute next state
  always_comb begin
    phase_nxt     = e_phase;
    hdr_idx_nxt   = e_idx;
    magic_nxt     = e_magic;
    prg_nxt       = e_prg;
    chr_nxt       = e_chr;
    flag6_nxt     = e_flag6;
    mapper_nxt    = e_mapper;
    off_nxt       = off_r;
    prg_len_nxt   = prg_len_r;
    total_nxt     = total_r;
    flags_nxt     = flags_r;
    cmd_valid     = 1'b0;
    cmd           = '0;
    cmd.data      = b;
    cmd.chr_zero  = (e_chr == 8'd0);
    case (e_phase)
      PH_HEADER: begin
        if ((e_idx == 4'd0) && (rom_length < HDR_LEN)) begin
          cmd_valid  = 1'b1;
          cmd.status = ST_TOO_SHORT;
          phase_nxt  = PH_DONE;
        end else begin
          magic_nxt   = e_magic & ~magic_bad;
          hdr_idx_nxt = e_idx + 4'd1;
          if (e_idx == 4'd4) begin
            prg_nxt = b;
          end
          if (e_idx == 4'd5) begin
            chr_nxt = b;
          end
          if (e_idx == 4'd6) begin
            flag6_nxt = b;
          end
          if (e_idx == 4'd7) begin
            mapper_nxt = (b & FLAG_HI_MASK) | {4'd0, e_flag6[7:4]};
          end
          // header verdict
          if (e_idx == HDR_LAST_IDX) begin
            off_nxt     = '0;
            prg_len_nxt = {e_prg[1:0], 14'd0};
            total_nxt   = {e_prg[1:0], 14'd0} + {2'b00, e_chr[0], 13'd0};
            flags_nxt   = ok_flags;
            if (!e_magic) begin
              cmd_valid  = 1'b1;
              cmd.status = ST_BAD_MAGIC;
              phase_nxt  = PH_DONE;
            end else if (e_mapper != 8'd0) begin
              cmd_valid  = 1'b1;
              cmd.status = ST_BAD_MAPPER;
              phase_nxt  = PH_DONE;
            end else if ((e_prg > MAX_PRG_BLKS) || (e_chr > MAX_CHR_BLKS)) begin
              cmd_valid  = 1'b1;
              cmd.status = ST_TOO_LARGE;
              phase_nxt  = PH_DONE;
            end else if (rom_length < {7'd0, need_len}) begin
              cmd_valid  = 1'b1;
              cmd.status = ST_TRUNCATED;
              phase_nxt  = PH_DONE;
            end else if ((e_prg == 8'd0) && (e_chr == 8'd0)) begin
              // empty body: fills and done right away
              cmd_valid  = 1'b1;
              cmd.finish = 1'b1;
              cmd.flags  = ok_flags;
              phase_nxt  = PH_DONE;
            end else begin
              phase_nxt = PH_LOAD;
            end
          end
        end
      end
      PH_LOAD: begin
        cmd_valid     = 1'b1;
        cmd.has_write = 1'b1;
        cmd.flags     = flags_r;
        if (off_r < prg_len_r) begin
          cmd.offset = off_r;
          cmd.mirror = (e_prg == 8'd1);
        end else begin
          cmd.offset = CHR_OFFSET + (off_r - prg_len_r);
        end
        off_nxt = off_r + 16'd1;
        if (({1'b0, off_r} + 17'd1) >= {1'b0, total_r}) begin
          cmd.finish = 1'b1;
          phase_nxt  = PH_DONE;
        end
      end
      default: begin
        cmd_valid = 1'b0;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HEADER;
      hdr_idx_r <= '0;
      magic_r   <= 1'b1;
      prg_r     <= '0;
      chr_r     <= '0;
      flag6_r   <= '0;
      mapper_r  <= '0;
    end else if (accept) begin
      phase_r   <= phase_nxt;
      hdr_idx_r <= hdr_idx_nxt;
      magic_r   <= magic_nxt;
      prg_r     <= prg_nxt;
      chr_r     <= chr_nxt;
      flag6_r   <= flag6_nxt;
      mapper_r  <= mapper_nxt;
    end
  end

  // load bookkeeping, set at the header verdict before use
  always_ff @(posedge clk) begin
    if (accept) begin
      off_r     <= off_nxt;
      prg_len_r <= prg_len_nxt;
      total_r   <= total_nxt;
      flags_r   <= flags_nxt;
    end
  end

endmodule

>>> sv/irl_cmd_fifo.sv
// ----------------------------------------------------------------------------
// irl_cmd_fifo
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module irl_cmd_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  irl_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output irl_pkg::cmd_t pop_data
);
  import irl_pkg::*;

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cmd_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> sv/irl_back.sv
// ----------------------------------------------------------------------------
// irl_back
// Expands the head command into results, one per cycle while the output
// register is empty or popped; it drains through the result queue interface.
// ----------------------------------------------------------------------------
module irl_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cmd_valid,
  input  irl_pkg::cmd_t    cmd,
  input  logic [31:0]      load_base,
  output logic             cmd_pop,
  output logic             out_empty,
  input  logic             out_pop,
  output irl_pkg::result_t out_result
);
  import irl_pkg::*;

  logic [NUM_STEPS-1:0] sent_r, sent_nxt;
  logic [NUM_STEPS-1:0] mask;
  logic [NUM_STEPS-1:0] remain;
  logic [NUM_STEPS-1:0] sel;
  logic                 out_valid_r, out_valid_nxt;
  result_t              out_r, out_nxt;
  logic                 advance;
  logic                 final_step;

  // steps the head command expands into
  always_comb begin
    mask                 = '0;
    mask[STEP_WRITE]     = cmd.has_write;
    mask[STEP_MIRROR]    = cmd.has_write & cmd.mirror;
    mask[STEP_CHR_FILL]  = cmd.finish & cmd.chr_zero;
    mask[STEP_VRAM_FILL] = cmd.finish;
    mask[STEP_WRAM_FILL] = cmd.finish;
    mask[STEP_DONE]      = cmd.finish | ~cmd.has_write;
  end

  // lowest step still to send
  assign remain     = mask & ~sent_r;
  assign sel        = remain & (~remain + NUM_STEPS'(1));
  assign final_step = ((remain & ~sel) == '0);
  assign advance    = cmd_valid && (!out_valid_r || out_pop);
  assign cmd_pop    = advance && final_step;

  // result for the selected step
  always_comb begin
    out_nxt      = '0;
    out_nxt.last = final_step;
    if (sel[STEP_WRITE]) begin
      out_nxt.kind    = KIND_WRITE;
      out_nxt.address = load_base + {16'd0, cmd.offset};
      out_nxt.data    = cmd.data;
    end else if (sel[STEP_MIRROR]) begin
      out_nxt.kind    = KIND_WRITE;
      out_nxt.address = load_base + {16'd0, cmd.offset + PRG_UNIT};
      out_nxt.data    = cmd.data;
    end else if (sel[STEP_CHR_FILL]) begin
      out_nxt.kind        = KIND_FILL;
      out_nxt.address     = load_base + {16'd0, CHR_OFFSET};
      out_nxt.fill_length = CHR_RAM_LEN;
    end else if (sel[STEP_VRAM_FILL]) begin
      out_nxt.kind        = KIND_FILL;
      out_nxt.address     = load_base + {16'd0, VRAM_OFFSET};
      out_nxt.fill_length = SMALL_RAM_LEN;
    end else if (sel[STEP_WRAM_FILL]) begin
      out_nxt.kind        = KIND_FILL;
      out_nxt.address     = load_base + {16'd0, WRAM_OFFSET};
      out_nxt.fill_length = SMALL_RAM_LEN;
    end else begin
      out_nxt.kind = KIND_DONE;
      if (cmd.finish) begin
        out_nxt.status = ST_OK;
        out_nxt.flags  = cmd.flags;
      end else begin
        out_nxt.status = cmd.status;
      end
    end
  end

  // step tracking and output valid
  always_comb begin
    sent_nxt      = sent_r;
    out_valid_nxt = out_valid_r;
    if (out_pop) begin
      out_valid_nxt = 1'b0;
    end
    if (advance) begin
      out_valid_nxt = 1'b1;
      sent_nxt      = final_step ? '0 : (sent_r | sel);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sent_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      sent_r      <= sent_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= out_nxt;
    end
  end

  assign out_empty  = !out_valid_r;
  assign out_result = out_r;

endmodule

>>> sv/ines_rom_image_loader.sv
// ----------------------------------------------------------------------------
// ines_rom_image_loader
// Parses a streamed iNES image (mapper 0) and turns it into byte writes,
// zero fill requests and a done result with status and packed flags.
//
//   channel   ports                                      direction
//   input     in_push, in_full, in_item                  in  (queue push)
//   result    out_empty, out_pop, out_result             out (queue pop)
//   config    cfg_valid, cfg_ready, cfg_index, cfg_data  in  (write only)
//
// One byte is taken per cycle while the command queue has room; the back end
// sends one result per cycle while its output register is free or popped, so
// a plain byte yields one result, a mirrored program byte two, and the
// closing byte up to six (writes, fills, done). A result is registered once
// its command heads the queue and the output register is free or popped.
// Either side may stall at any time without loss.
// ----------------------------------------------------------------------------
module ines_rom_image_loader #(
  parameter int unsigned CMD_DEPTH = 2
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input
  input  logic                            in_push,
  output logic                            in_full,
  input  irl_pkg::in_item_t               in_item,
  // results
  output logic                            out_empty,
  input  logic                            out_pop,
  output irl_pkg::result_t                out_result,
  // configuration
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [irl_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]                     cfg_data
);
  import irl_pkg::*;

  logic [23:0] rom_length_r;
  logic [31:0] load_base_r;
  logic        accept;
  logic        fr_cmd_valid;
  cmd_t        fr_cmd;
  logic        q_not_empty;
  cmd_t        q_head;
  logic        q_pop;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rom_length_r <= '0;
      load_base_r  <= LOAD_BASE_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_ROM_LENGTH) begin
        rom_length_r <= cfg_data[23:0];
      end else if (cfg_index == CFG_LOAD_BASE) begin
        load_base_r <= cfg_data;
      end
    end
  end

  // input request accepted
  assign accept = in_push && !in_full;

  irl_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .in_item    (in_item),
    .rom_length (rom_length_r),
    .cmd_valid  (fr_cmd_valid),
    .cmd        (fr_cmd)
  );

  irl_cmd_fifo #(
    .DEPTH (CMD_DEPTH)
  ) u_cmd_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept && fr_cmd_valid),
    .push_data (fr_cmd),
    .full      (in_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (q_head)
  );

  irl_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (q_not_empty),
    .cmd        (q_head),
    .load_base  (load_base_r),
    .cmd_pop    (q_pop),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_result (out_result)
  );

endmodule
